@@ design/sspg_pkg.sv @@
// Shared constants and the quarter-wave sine generator for the stereo sine oscillator.
package sspg_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TUNING_WORD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN         = 2'd2;

    localparam logic [31:0] TUNING_WORD_RESET = 32'd194783097;
    localparam logic [15:0] VOLUME_RESET      = 16'd16384;
    localparam logic [15:0] PAN_RESET         = 16'd16384;

    localparam logic [15:0] UNITY_Q15   = 16'd32768;
    localparam logic [17:0] GLIDE_COEF  = 18'd3277;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] QS_SCALE    = 64'd32767;
    localparam logic [63:0] QS_HALF     = 64'd536870912;

    // Two Q30 multiplies by the angle: term * x^2.
    function automatic logic [63:0] qs_sq(logic [63:0] t, logic [63:0] x);
        logic [63:0] r;
        r = (t * x) >> 30;
        r = (r * x) >> 30;
        return r;
    endfunction

    // round(32767 * sin(pi/2 * m / 2^qbits)) by a Taylor series in Q30.
    function automatic logic [14:0] quarter_sine(logic [31:0] m, int unsigned qbits);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x = (HALF_PI_Q30 * {32'd0, m}) >> qbits;
        s = x;
        t = qs_sq(x, x) / 64'd6;
        s = s - t;
        t = qs_sq(t, x) / 64'd20;
        s = s + t;
        t = qs_sq(t, x) / 64'd42;
        s = s - t;
        t = qs_sq(t, x) / 64'd72;
        s = s + t;
        t = qs_sq(t, x) / 64'd110;
        s = s - t;
        t = qs_sq(t, x) / 64'd156;
        s = s + t;
        v = (s * QS_SCALE + QS_HALF) >> 30;
        if (v > QS_SCALE)
        begin
            v = QS_SCALE;
        end
        return v[14:0];
    endfunction

endpackage

@@ design/sspg_sine_rom.sv @@
// Quarter-wave sine ROM with quadrant folding and registered read.
module sspg_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                   clk,
    input  logic [TABLE_BITS-1:0]  idx,
    output logic signed [15:0]     sample
);
    import sspg_pkg::*;

    localparam int QBITS = TABLE_BITS - 2;
    localparam int QLEN  = 1 << QBITS;
    localparam int AB    = TABLE_BITS - 1;

    typedef logic [14:0] qrom_t [QLEN+1];

    function automatic qrom_t build_qrom();
        qrom_t rom;
        for (int m = 0; m <= QLEN; m++)
        begin
            rom[m] = quarter_sine(32'(m), QBITS);
        end
        return rom;
    endfunction

    localparam qrom_t QROM = build_qrom();

    logic [QBITS-1:0] frac;
    logic [AB-1:0]    addr;
    logic [14:0]      data_reg;
    logic             neg_reg;

    assign frac = idx[QBITS-1:0];
    assign addr = idx[QBITS] ? (AB'(QLEN) - {1'b0, frac}) : {1'b0, frac};

    always_ff @(posedge clk)
    begin
        data_reg <= QROM[addr];
        neg_reg  <= idx[TABLE_BITS-1];
    end

    assign sample = neg_reg ? -$signed({1'b0, data_reg}) : $signed({1'b0, data_reg});

endmodule

@@ design/stereo_sine_oscillator_pan_glide_unit.sv @@
// Top level of the stereo sine oscillator with pan and per-block frequency glide.
//
// Usage:
//   Input channel (in_valid/in_ready, first_of_block): one transaction is one
//   sample tick. first_of_block applies one glide step of the phase increment
//   toward tuning_word before the phase advances.
//   Output channel (out_valid/out_ready, left_sample, right_sample): one
//   transaction per input transaction, in order, signed and saturated.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 tuning_word,
//   1 volume, 2 pan; always ready, write only while the block is idle.
// Sequencing:
//   One shared signed multiplier does the glide product, sample*volume and the
//   two pan shares in turn. An accepted transaction steps through S_PHASE,
//   S_READ, S_MVOL, S_MLEFT, S_MRIGHT and S_FIN (after S_GMUL and S_GADD with
//   first_of_block); in_ready is high only between items, so the next one is
//   taken only once S_FIN has passed the result on. The ROM read is registered.
// Reset clears phase and increment and loads the register defaults.
// If the receiver stalls, the finished result waits in the output register and
// the next result is held inside until the output register frees up.
module stereo_sine_oscillator_pan_glide_unit #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               first_of_block,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [15:0]                 left_sample,
    output logic signed [15:0]                 right_sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sspg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                        cfg_data
);
    import sspg_pkg::*;

    localparam int AW = (PHASE_BITS + 1 > 33) ? PHASE_BITS + 1 : 33;
    localparam int PW = AW + 18;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GMUL   = 4'd1;
    localparam logic [3:0] S_GADD   = 4'd2;
    localparam logic [3:0] S_PHASE  = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_MVOL   = 4'd5;
    localparam logic [3:0] S_MLEFT  = 4'd6;
    localparam logic [3:0] S_MRIGHT = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [31:0]               tuning_word_reg;
    logic [15:0]               volume_reg;
    logic [15:0]               pan_reg;
    logic [PHASE_BITS-1:0]     phase_reg;
    logic [PHASE_BITS-1:0]     inc_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [32:0]        p1_reg;
    logic signed [15:0]        left_tmp_reg;
    logic signed [15:0]        left_sample_reg;
    logic signed [15:0]        right_sample_reg;
    logic                      out_valid_reg;

    logic [PHASE_BITS-1:0]     target;
    logic signed [PHASE_BITS:0] diff;
    logic [15:0]               right_share;
    logic [15:0]               left_share;
    logic signed [15:0]        sample;
    logic signed [AW-1:0]      mul_a;
    logic signed [17:0]        mul_b;
    logic signed [PW-1:0]      mul_p;
    logic                      out_free;
    logic                      out_load;

    function automatic logic signed [15:0] round_sat(logic signed [50:0] p);
        logic signed [50:0] r;
        r = (p + 51'sd536870912) >>> 30;
        if (r > 51'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (r < -51'sd32768)
        begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    sspg_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk    (clk),
        .idx    (phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .sample (sample)
    );

    assign target      = PHASE_BITS'(tuning_word_reg);
    assign diff        = $signed({1'b0, target}) - $signed({1'b0, inc_reg});
    assign right_share = (pan_reg > UNITY_Q15) ? UNITY_Q15 : pan_reg;
    assign left_share  = UNITY_Q15 - right_share;

    always_comb
    begin
        unique case (state_reg)
            S_GMUL:
            begin
                mul_a = AW'(diff);
                mul_b = $signed(GLIDE_COEF);
            end
            S_MVOL:
            begin
                mul_a = AW'(sample);
                mul_b = $signed({2'b00, volume_reg});
            end
            S_MLEFT:
            begin
                mul_a = AW'(p1_reg);
                mul_b = $signed({2'b00, left_share});
            end
            S_MRIGHT:
            begin
                mul_a = AW'(p1_reg);
                mul_b = $signed({2'b00, right_share});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = first_of_block ? S_GMUL : S_PHASE;
                end
            end
            S_GMUL:   state_next = S_GADD;
            S_GADD:   state_next = S_PHASE;
            S_PHASE:  state_next = S_READ;
            S_READ:   state_next = S_MVOL;
            S_MVOL:   state_next = S_MLEFT;
            S_MLEFT:  state_next = S_MRIGHT;
            S_MRIGHT: state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tuning_word_reg <= TUNING_WORD_RESET;
            volume_reg      <= VOLUME_RESET;
            pan_reg         <= PAN_RESET;
            phase_reg       <= '0;
            inc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_TUNING_WORD: tuning_word_reg <= cfg_data;
                    REG_VOLUME:      volume_reg      <= cfg_data[15:0];
                    REG_PAN:         pan_reg         <= cfg_data[15:0];
                    default:         ;
                endcase
            end
            if (state_reg == S_GADD)
            begin
                inc_reg <= inc_reg + prod_reg[16 +: PHASE_BITS];
            end
            if (state_reg == S_PHASE)
            begin
                phase_reg <= phase_reg + inc_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_GMUL || state_reg == S_MLEFT || state_reg == S_MRIGHT)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_MVOL)
        begin
            p1_reg <= mul_p[32:0];
        end
        if (state_reg == S_MRIGHT)
        begin
            left_tmp_reg <= round_sat(prod_reg[50:0]);
        end
        if (out_load)
        begin
            left_sample_reg  <= left_tmp_reg;
            right_sample_reg <= round_sat(prod_reg[50:0]);
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign left_sample  = left_sample_reg;
    assign right_sample = right_sample_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start the sequencer");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !out_ready) |=> (state_reg == S_FIN))
        else $error("result left the sequencer while the output register was full");

    a_phase_only_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PHASE) |=> $stable(phase_reg))
        else $error("phase accumulator changed outside its update step");

    a_inc_only_in_glide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_GADD) |=> $stable(inc_reg))
        else $error("phase increment changed outside the glide step");

endmodule

@@ verif/stereo_sine_oscillator_pan_glide_unit_checker.sv @@
// Checker for the stereo sine oscillator: tracks config, predicts each sample pair, compares outputs.
module stereo_sine_oscillator_pan_glide_unit_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                first_of_block,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [15:0]                  left_sample,
    input  logic signed [15:0]                  right_sample,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [sspg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_data,
    output int unsigned                         fault_count,
    output int unsigned                         tones_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sspg_pkg::*;

    typedef struct packed
    {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_t;

    logic signed [15:0] sine_lut [0:1023];
    logic [31:0]        phase_q;
    logic [31:0]        inc_q;
    logic [31:0]        tw_q;
    logic [15:0]        vol_q;
    logic [15:0]        pan_q;
    stereo_t            tones_due [$];
    int unsigned        faults = 0;

    assign fault_count = faults;

    // Q30 Taylor series of a quarter wave, 256 steps per quarter
    function automatic logic signed [15:0] quarter_wave(int unsigned m);
        logic [63:0] ang;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        ang  = (64'd1686629713 * m) / 64'd256;
        term = ang;
        acc  = ang;
        for (int i = 1; i <= 6; i++)
        begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        v = (acc * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] scale_q15(logic signed [15:0] s, logic [15:0] g,
                                                      logic [16:0] share);
        longint p;
        p = s;
        p = p * longint'({48'd0, g}) * longint'({47'd0, share});
        p = (p + 64'sd536870912) >>> 30;
        if (p > 32767)
            return 16'sd32767;
        if (p < -32768)
            return -16'sd32768;
        return p[15:0];
    endfunction

    function automatic stereo_t next_tone(logic glide);
        longint      diff;
        longint      stp;
        logic [16:0] rshare;
        logic [16:0] lshare;
        stereo_t     res;
        if (glide)
        begin
            diff  = longint'({32'd0, tw_q}) - longint'({32'd0, inc_q});
            stp   = (diff * 3277) >>> 16;
            inc_q = inc_q + stp[31:0];
        end
        phase_q   = phase_q + inc_q;
        rshare    = (pan_q > 16'd32768) ? 17'd32768 : {1'b0, pan_q};
        lshare    = 17'd32768 - rshare;
        res.left  = scale_q15(sine_lut[phase_q[31:22]], vol_q, lshare);
        res.right = scale_q15(sine_lut[phase_q[31:22]], vol_q, rshare);
        return res;
    endfunction

    initial
    begin
        for (int k = 0; k < 1024; k++)
        begin
            case (k / 256)
                0:       sine_lut[k] = quarter_wave(k % 256);
                1:       sine_lut[k] = quarter_wave(256 - k % 256);
                2:       sine_lut[k] = -quarter_wave(k % 256);
                default: sine_lut[k] = -quarter_wave(256 - k % 256);
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        stereo_t want;
        if (!rst_n)
        begin
            phase_q = '0;
            inc_q   = '0;
            tw_q    = TUNING_WORD_RESET;
            vol_q   = VOLUME_RESET;
            pan_q   = PAN_RESET;
            tones_due.delete();
            tones_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TUNING_WORD: tw_q  = cfg_data;
                    REG_VOLUME:      vol_q = cfg_data[15:0];
                    REG_PAN:         pan_q = cfg_data[15:0];
                    default:         ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (tones_due.size() == 0)
                begin
                    faults++;
                    $display("%0t unexpected transaction: left %0d right %0d",
                             $time, left_sample, right_sample);
                end
                else
                begin
                    want = tones_due.pop_front();
                    if (want.left !== left_sample)
                    begin
                        faults++;
                        $display("%0t left_sample: expected %0d, actual %0d",
                                 $time, want.left, left_sample);
                    end
                    if (want.right !== right_sample)
                    begin
                        faults++;
                        $display("%0t right_sample: expected %0d, actual %0d",
                                 $time, want.right, right_sample);
                    end
                end
            end
            if (in_valid && in_ready)
                tones_due.push_back(next_tone(first_of_block));
            tones_pending <= tones_due.size();
        end
    end

endmodule

@@ verif/stereo_sine_oscillator_pan_glide_unit_tb.sv @@
// Testbench top for the stereo sine oscillator: clock, reset, stimulus, back-pressure and verdict.
module stereo_sine_oscillator_pan_glide_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sspg_pkg::*;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED   = 2'd3;
    localparam int                        WATCHDOG_LIMIT = 5000;
    localparam int                        TAIL_CYCLES    = 30;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      in_valid       = 1'b0;
    logic                      in_ready;
    logic                      first_of_block = 1'b0;
    logic                      out_valid;
    logic                      out_ready      = 1'b0;
    logic signed [15:0]        left_sample;
    logic signed [15:0]        right_sample;
    logic                      cfg_valid      = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = REG_TUNING_WORD;
    logic [31:0]               cfg_data       = '0;
    int unsigned               fault_count;
    int unsigned               tones_pending;
    idle_mode_t                idle_mode      = IDLE_NONE;
    int unsigned               quiet_cycles   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    stereo_sine_oscillator_pan_glide_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_of_block (first_of_block),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    stereo_sine_oscillator_pan_glide_unit_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_of_block (first_of_block),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fault_count    (fault_count),
        .tones_pending  (tones_pending)
    );

    always @(posedge clk or negedge rst_n)
    begin
        int stall_pct;
        stall_pct = (idle_mode == IDLE_RECEIVER) ? 54 : (idle_mode == IDLE_BOTH) ? 21 : 0;
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stereo_sine_oscillator_pan_glide_unit: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_regs(logic [31:0] tw, logic [31:0] vol_data, logic [31:0] pan_data);
        write_reg(REG_TUNING_WORD, tw);
        write_reg(REG_VOLUME, vol_data);
        write_reg(REG_PAN, pan_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(logic first);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SENDER) ? 54 : (idle_mode == IDLE_BOTH) ? 21 : 0;
        while ($urandom_range(0, 99) < pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        first_of_block <= first;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off new samples until every predicted pair has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tones_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return UNITY_Q15;
            2:       return 16'hFFFF;
            5:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [31:0] pick_tuning();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(1000000, 400000000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int n;
        int glide_pct;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: increment starts at zero, then glides up
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (6) send_tick(1'b1);
        send_tick(1'b0);
        drain();
        // full-scale target, volume above unity saturates the right channel
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32768);
        repeat (5) send_tick(1'b1);
        drain();
        // zero target glides down, hard left
        set_regs(32'd0, 32'd32768, 32'd0);
        repeat (4) send_tick(1'b1);
        drain();
        write_reg(REG_UNMAPPED, $urandom);
        set_regs(32'h4000_0000, 32'd0, 32'd65535);
        repeat (3) send_tick(1'b1);
        drain();
        set_regs(32'h4000_0000, 32'd32768, 32'd65535);
        repeat (3) send_tick(1'b1);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            idle_mode = idle_mode_t'(p % 4);
            set_regs(pick_tuning(), {16'($urandom), pick_gain()}, {16'($urandom), pick_gain()});
            n = $urandom_range(100, 200);
            case ($urandom_range(0, 2))
                0:       glide_pct = 10;
                1:       glide_pct = 50;
                default: glide_pct = 100;
            endcase
            for (int i = 0; i < n; i++)
            begin
                if (p == 5 && i == n / 2)
                    drain();
                send_tick($urandom_range(0, 99) < glide_pct);
            end
            drain();
        end

        idle_mode = IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && tones_pending == 0)
            $display("stereo_sine_oscillator_pan_glide_unit: match");
        else
            $display("stereo_sine_oscillator_pan_glide_unit: mismatch");
        $finish;
    end

endmodule
